// ===== sv/assert_macros.svh =====
// Assertion macros for the checker of the text console writer.
// No dependencies; every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tcw_pkg.sv =====
// Shared constants and types of the text console character writer.
// No dependencies; used by tcw_cursor, the top level, the checker and the testbench.
package tcw_pkg;

  localparam int TCW_COLUMNS = 80;
  localparam int TCW_ROWS    = 25;

  localparam logic [2:0] OP_PUT       = 3'd0;
  localparam logic [2:0] OP_CLEAR     = 3'd1;
  localparam logic [2:0] OP_SET       = 3'd2;
  localparam logic [2:0] OP_SCROLL_UP = 3'd3;
  localparam logic [2:0] OP_SCROLL_DN = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  localparam logic [7:0] CH_BS         = 8'h08;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LAST_PRINT = 8'h7F;

  localparam logic [7:0]  ATTR_RESET = 8'h07;
  localparam logic [15:0] CELL_RESET = 16'h0720;

  // Control flags handed from the cursor logic to the sequencer.
  typedef struct packed {
    logic wr;      // write one cell for this character
    logic scroll;  // row ran past the last one
  } put_ctl_t;

endpackage

// ===== sv/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tcw_cursor.sv =====
// Cursor update for one put-character item: next row and column, and the cell to write.
// Depends on tcw_pkg.
module tcw_cursor import tcw_pkg::*; #(
  parameter int ROWS    = TCW_ROWS,
  parameter int COLUMNS = TCW_COLUMNS,
  localparam int RW  = $clog2(ROWS + 1),
  localparam int CLW = $clog2(COLUMNS + 8),
  localparam int AW  = $clog2(ROWS * COLUMNS)
) (
  input  logic [RW-1:0]  row,
  input  logic [CLW-1:0] col,
  input  logic [7:0]     char_code,
  input  logic [7:0]     attr,
  output logic [RW-1:0]  row_next,
  output logic [CLW-1:0] col_next,
  output logic [AW-1:0]  wr_addr,
  output logic [15:0]    wr_data,
  output put_ctl_t       ctl
);

  logic [AW-1:0]  base;
  logic [CLW-1:0] col_tab;
  logic [CLW-1:0] col_inc;

  assign base    = AW'(row) * AW'(COLUMNS);
  assign col_tab = (col + CLW'(8)) & ~CLW'(7);
  assign col_inc = col + CLW'(1);

  always_comb begin
    row_next = row;
    col_next = col;
    wr_addr  = base + AW'(col);
    wr_data  = {attr, char_code};
    ctl      = '0;
    if (char_code == CH_LF) begin
      col_next = '0;
      row_next = row + RW'(1);
    end else if (char_code == CH_CR) begin
      col_next = '0;
    end else if (char_code == CH_TAB) begin
      if (int'(col_tab) >= COLUMNS) begin
        col_next = '0;
        row_next = row + RW'(1);
      end else begin
        col_next = col_tab;
      end
    end else if (char_code == CH_BS) begin
      // Backspace blanks the cell it steps back onto.
      if (col != '0) begin
        col_next = col - CLW'(1);
        wr_addr  = base + AW'(col - CLW'(1));
        wr_data  = {attr, CH_SPACE};
        ctl.wr   = 1'b1;
      end
    end else if (char_code >= CH_SPACE && char_code <= CH_LAST_PRINT) begin
      ctl.wr = 1'b1;
      if (int'(col_inc) >= COLUMNS) begin
        col_next = '0;
        row_next = row + RW'(1);
      end else begin
        col_next = col_inc;
      end
    end
    ctl.scroll = int'(row_next) >= ROWS;
  end

endmodule

// ===== sv/text_console_char_writer_unit.sv =====
// Top level of the text console character writer: sequencer, cell store and cursor.
// Depends on tcw_pkg, tcw_ram and tcw_cursor.
//
// The block keeps a ROWS x COLUMNS store of 16-bit cells (attribute in the high
// byte, character in the low byte) and a write cursor. An item is taken when
// start is high and busy is low; its single result appears for exactly one cycle
// with done high and cannot be held off, so the receiver must take it then.
// Put character, set cursor and the unused op codes answer from the execute state,
// read cell from the read state. Scroll up and scroll down walk the store through
// its one read and one write port with a single address adder: they copy the moved
// cells, pass a drain state and then blank the row that entered. A put that runs
// past the last row writes its cell in the execute state and then runs that scroll.
// Clear writes one cell a cycle. After reset, busy stays high for a clearing pass
// that sets every cell to 0x0720; the attribute register may be written during that
// pass. The attribute register is meant to be written only while the block is idle.
module text_console_char_writer_unit import tcw_pkg::*; #(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [7:0]  char_code,
  input  logic [7:0]  target_row,
  input  logic [7:0]  target_col,
  input  logic [10:0] cell_index,
  output logic        done,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic [10:0] cursor_linear,
  output logic [15:0] cell_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int NCOPY = (ROWS - 1) * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CLW   = $clog2(COLUMNS + 8);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_READ = 6'b000100,
    S_CPY  = 6'b001000,
    S_DRN  = 6'b010000,
    S_FILL = 6'b100000
  } state_t;

  state_t state;

  // Cursor and attribute.
  logic [RW-1:0]  row;
  logic [CLW-1:0] col;
  logic [7:0]     attr;

  // Item captured at acceptance.
  logic [2:0] op_r;
  logic [7:0] ch_r;
  logic [7:0] tr_r;
  logic [7:0] tc_r;
  logic       idx_ok;

  // Walk state: a is the copy pointer and later the fill address.
  logic [AW-1:0] a;
  logic [AW-1:0] sum;
  logic [AW-1:0] cp_dst;
  logic          cp_v;
  logic          dir_up;
  logic          cp_last;
  logic [AW-1:0] fill_end;
  logic          fill_init;

  logic [15:0]   cell_q;
  logic [AW-1:0] lin;

  // Store ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  // Put-character results.
  logic [RW-1:0]  put_row;
  logic [CLW-1:0] put_col;
  logic [AW-1:0]  put_addr;
  logic [15:0]    put_data;
  put_ctl_t       put_ctl;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_cursor (
    .row       (row),
    .col       (col),
    .char_code (ch_r),
    .attr      (attr),
    .row_next  (put_row),
    .col_next  (put_col),
    .wr_addr   (put_addr),
    .wr_data   (put_data),
    .ctl       (put_ctl)
  );

  assign busy = (state != S_IDLE);

  // The one address adder: source of an upward copy, destination of a downward one.
  assign sum     = a + AW'(COLUMNS);
  assign cp_last = dir_up ? (a == AW'(NCOPY - 1)) : (a == '0);

  // Store port selection. While idle the read port follows cell_index so a read
  // item has its data in the cycle after acceptance.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cp_dst;
    ram_wdata = ram_rdata;
    ram_raddr = AW'(cell_index);
    case (state)
      S_EXEC: begin
        ram_we    = (op_r == OP_PUT) && put_ctl.wr;
        ram_waddr = put_addr;
        ram_wdata = put_data;
      end
      S_CPY: begin
        // Each cycle issues one read and, once cp_v is set, writes the cell read the cycle before.
        ram_we    = cp_v;
        ram_raddr = dir_up ? sum : a;
      end
      S_DRN: begin
        ram_we = 1'b1;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = a;
        ram_wdata = fill_init ? CELL_RESET : {attr, CH_SPACE};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      a         <= '0;
      fill_end  <= AW'(CELLS - 1);
      fill_init <= 1'b1;
      row       <= '0;
      col       <= '0;
      attr      <= ATTR_RESET;
      done      <= 1'b0;
      cp_v      <= 1'b0;
      dir_up    <= 1'b1;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r   <= op;
            ch_r   <= char_code;
            tr_r   <= target_row;
            tc_r   <= target_col;
            idx_ok <= int'(cell_index) < CELLS;
            case (op)
              OP_CLEAR: begin
                a         <= '0;
                fill_end  <= AW'(CELLS - 1);
                fill_init <= 1'b0;
                row       <= '0;
                col       <= '0;
                state     <= S_FILL;
              end
              OP_SCROLL_UP: begin
                a      <= '0;
                dir_up <= 1'b1;
                cp_v   <= 1'b0;
                state  <= S_CPY;
              end
              OP_SCROLL_DN: begin
                a      <= AW'(NCOPY - 1);
                dir_up <= 1'b0;
                cp_v   <= 1'b0;
                state  <= S_CPY;
              end
              OP_READ: begin
                state <= S_READ;
              end
              default: begin
                state <= S_EXEC;
              end
            endcase
          end
        end
        S_EXEC: begin
          case (op_r)
            OP_PUT: begin
              row <= put_ctl.scroll ? RW'(ROWS - 1) : put_row;
              col <= put_col;
              if (put_ctl.scroll) begin
                // The written cell lands before the rows move up.
                a      <= '0;
                dir_up <= 1'b1;
                cp_v   <= 1'b0;
                state  <= S_CPY;
              end else begin
                done   <= 1'b1;
                cell_q <= '0;
                state  <= S_IDLE;
              end
            end
            OP_SET: begin
              row    <= (int'(tr_r) >= ROWS) ? RW'(ROWS - 1) : RW'(tr_r);
              col    <= (int'(tc_r) >= COLUMNS) ? CLW'(COLUMNS - 1) : CLW'(tc_r);
              done   <= 1'b1;
              cell_q <= '0;
              state  <= S_IDLE;
            end
            default: begin
              done   <= 1'b1;
              cell_q <= '0;
              state  <= S_IDLE;
            end
          endcase
        end
        S_READ: begin
          done   <= 1'b1;
          cell_q <= idx_ok ? ram_rdata : '0;
          state  <= S_IDLE;
        end
        S_CPY: begin
          cp_v   <= 1'b1;
          cp_dst <= dir_up ? a : sum;
          if (cp_last) begin
            state <= S_DRN;
          end else begin
            a <= dir_up ? (a + AW'(1)) : (a - AW'(1));
          end
        end
        S_DRN: begin
          // Last copied cell is written now; then blank the row that entered.
          a         <= dir_up ? AW'(NCOPY) : '0;
          fill_end  <= dir_up ? AW'(CELLS - 1) : AW'(COLUMNS - 1);
          fill_init <= 1'b0;
          state     <= S_FILL;
        end
        S_FILL: begin
          if (a == fill_end) begin
            fill_init <= 1'b0;
            // The clearing pass after reset answers no item.
            if (!fill_init) begin
              done   <= 1'b1;
              cell_q <= '0;
            end
            state <= S_IDLE;
          end else begin
            a <= a + AW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Cursor fields follow the cursor registers, which hold still while done is high.
  assign lin           = AW'(row) * AW'(COLUMNS) + AW'(col);
  assign cursor_row    = 5'(row);
  assign cursor_col    = 7'(col);
  assign cursor_linear = 11'(lin);
  assign cell_data     = cell_q;

endmodule

// ===== sv/tcw_checker.sv =====
// Port-level checks of the text console character writer, bound to its top level.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [4:0] cursor_row,
  input logic [6:0] cursor_col
);

  // A result only comes out once the item's work has finished.
  `TCW_ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")
  `TCW_ASSERT_SAME(a_done_after_work, done, $past(busy), "result without preceding work")
  // An accepted item always occupies the block and never answers at once.
  `TCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted item not started")
  `TCW_ASSERT_SAME(a_col_range, done, int'(cursor_col) < COLUMNS, "cursor column past last")
  `TCW_ASSERT_SAME(a_row_range, done, int'(cursor_row) < ROWS, "cursor row past last")

endmodule

bind text_console_char_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .cursor_row (cursor_row),
  .cursor_col (cursor_col)
);

// ===== test/tb_text_console_char_writer_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the text console character writer: directed and random
// items, a shadow of the cell store and cursor, and a field-by-field result check.
// Depends on tcw_pkg and text_console_char_writer_unit.

// Shadow copy of the console: cell store, cursor and attribute, plus the queue of
// cursor reports that accepted items still owe.
class console_shadow;
  localparam int COLS  = tcw_pkg::TCW_COLUMNS;
  localparam int LINES = tcw_pkg::TCW_ROWS;
  localparam int COUNT = COLS * LINES;

  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [10:0] lin;
    logic [15:0] data;
  } cursor_report_t;

  logic [15:0]    screen [COUNT];
  int unsigned    row_now;
  int unsigned    col_now;
  logic [7:0]     attr;
  cursor_report_t awaited [$];
  int unsigned    errors;

  function new();
    foreach (screen[i]) screen[i] = tcw_pkg::CELL_RESET;
    row_now = 0;
    col_now = 0;
    attr    = tcw_pkg::ATTR_RESET;
    errors  = 0;
  endfunction

  function void set_attr(logic [7:0] value);
    attr = value;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  function logic [15:0] blank();
    return {attr, tcw_pkg::CH_SPACE};
  endfunction

  function void next_line();
    col_now = 0;
    row_now++;
  endfunction

  function void shift_up();
    for (int i = 0; i < COUNT - COLS; i++) screen[i] = screen[i + COLS];
    for (int i = COUNT - COLS; i < COUNT; i++) screen[i] = blank();
  endfunction

  // Applies one accepted item and queues the report it must produce.
  function void take_item(logic [2:0] code, logic [7:0] ch, logic [7:0] tr, logic [7:0] tc,
                          logic [10:0] idx);
    logic [15:0]    read_back;
    cursor_report_t r;
    read_back = '0;
    case (code)
      tcw_pkg::OP_PUT: begin
        if (ch == tcw_pkg::CH_LF) begin
          next_line();
        end else if (ch == tcw_pkg::CH_CR) begin
          col_now = 0;
        end else if (ch == tcw_pkg::CH_TAB) begin
          col_now = (col_now + 8) & ~32'd7;
          if (col_now >= COLS) next_line();
        end else if (ch == tcw_pkg::CH_BS) begin
          if (col_now > 0) begin
            col_now--;
            screen[row_now * COLS + col_now] = blank();
          end
        end else if (ch >= tcw_pkg::CH_SPACE && ch <= tcw_pkg::CH_LAST_PRINT) begin
          screen[row_now * COLS + col_now] = {attr, ch};
          col_now++;
          if (col_now >= COLS) next_line();
        end
        if (row_now >= LINES) begin
          shift_up();
          row_now = LINES - 1;
        end
      end
      tcw_pkg::OP_CLEAR: begin
        foreach (screen[i]) screen[i] = blank();
        row_now = 0;
        col_now = 0;
      end
      tcw_pkg::OP_SET: begin
        row_now = (tr >= LINES) ? LINES - 1 : tr;
        col_now = (tc >= COLS) ? COLS - 1 : tc;
      end
      tcw_pkg::OP_SCROLL_UP: shift_up();
      tcw_pkg::OP_SCROLL_DN: begin
        for (int i = COUNT - 1; i >= COLS; i--) screen[i] = screen[i - COLS];
        for (int i = 0; i < COLS; i++) screen[i] = blank();
      end
      tcw_pkg::OP_READ: if (idx < COUNT) read_back = screen[idx];
      default: ;
    endcase
    r.row  = row_now[4:0];
    r.col  = col_now[6:0];
    r.lin  = 11'(row_now * COLS + col_now);
    r.data = read_back;
    awaited.push_back(r);
  endfunction

  task flag(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task check_result(logic [4:0] row, logic [6:0] col, logic [10:0] lin, logic [15:0] data);
    cursor_report_t want;
    if (awaited.size() == 0) begin
      flag($sformatf("result with no item pending (row %0d col %0d)", row, col));
      return;
    end
    want = awaited.pop_front();
    if (row !== want.row)
      flag($sformatf("cursor_row %0d, expected %0d", row, want.row));
    if (col !== want.col)
      flag($sformatf("cursor_col %0d, expected %0d", col, want.col));
    if (lin !== want.lin)
      flag($sformatf("cursor_linear %0d, expected %0d", lin, want.lin));
    if (data !== want.data)
      flag($sformatf("cell_data %h, expected %h", data, want.data));
  endtask

  task close_out();
    cursor_report_t want;
    while (awaited.size() > 0) begin
      want = awaited.pop_front();
      flag($sformatf("no result for item expecting row %0d col %0d", want.row, want.col));
    end
  endtask
endclass

module tb_text_console_char_writer_unit;
  import tcw_pkg::*;

  // The two op codes that the block leaves unused.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int PHASES           = 4;
  localparam int ITEMS_PER_PHASE  = 150;
  // A put that runs off the bottom row is the slowest item: its execute step in front
  // of a full scroll (moved cells, the drain step, one blank row).
  localparam int LONGEST_ITEM     = 1 + (TCW_ROWS - 1) * TCW_COLUMNS + 1 + TCW_COLUMNS;
  // Slowest correct run: the clearing pass after reset, then every item (directed and
  // random, with margin) taking the longest path plus the widest sender gap. Three
  // times that is the point at which the run is declared hung.
  localparam int CYCLE_LIMIT      =
    3 * (TCW_ROWS * TCW_COLUMNS + (PHASES * ITEMS_PER_PHASE + 50) * (LONGEST_ITEM + 4));

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        start;
  logic        busy;
  logic [2:0]  op;
  logic [7:0]  char_code;
  logic [7:0]  target_row;
  logic [7:0]  target_col;
  logic [10:0] cell_index;
  logic        done;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic [10:0] cursor_linear;
  logic [15:0] cell_data;

  console_shadow shadow;
  int unsigned   cycle_count;

  text_console_char_writer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .char_code     (char_code),
    .target_row    (target_row),
    .target_col    (target_col),
    .cell_index    (cell_index),
    .done          (done),
    .cursor_row    (cursor_row),
    .cursor_col    (cursor_col),
    .cursor_linear (cursor_linear),
    .cell_data     (cell_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The monitor samples everything at the rising edge, before any of this edge's
  // nonblocking updates land, so it sees exactly what the block sees. Attribute
  // writes and accepted items update the shadow; every done strobe is checked
  // against the oldest pending report. An item can never finish in the cycle it is
  // taken, so noting the item before checking the strobe keeps the order right.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) shadow.set_attr(cfg_wdata);
      if (start && !busy) shadow.take_item(op, char_code, target_row, target_col, cell_index);
      if (done) shadow.check_result(cursor_row, cursor_col, cursor_linear, cell_data);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Presents one item and returns at the edge where it is taken. With may_idle set,
  // start first drops about 38 times in a hundred. Such a gap starts right after an
  // acceptance, so it either overlaps the first cycles of the previous item's work or,
  // after a short item, leaves the block idle. Otherwise start stays high after
  // acceptance, so back-to-back items never lower and raise it within one time step.
  task automatic send_item(input logic [2:0] code, input logic [7:0] ch, input logic [7:0] tr,
                           input logic [7:0] tc, input logic [10:0] idx, input bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    op         <= code;
    char_code  <= ch;
    target_row <= tr;
    target_col <= tc;
    cell_index <= idx;
    do @(posedge clk); while (busy);
  endtask

  task automatic put_byte(input logic [7:0] ch);
    send_item(OP_PUT, ch, 8'd0, 8'd0, 11'd0, 1'b0);
  endtask

  task automatic read_at(input logic [10:0] idx);
    send_item(OP_READ, 8'd0, 8'd0, 8'd0, idx, 1'b0);
  endtask

  // Drops start and waits until every report has come back and the block is idle.
  // The test is made at the falling edge, where this cycle's updates have settled,
  // and the task returns on the next rising edge so driving stays edge aligned.
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (shadow.pending() != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random item. Most items are text going through the cursor (printable bytes
  // with line controls mixed in), with cursor moves, reads, the store walks and the
  // unused codes making up the rest. Fields that an op ignores carry random values.
  task automatic random_item(input bit may_idle);
    int unsigned roll;
    int unsigned pick;
    logic [2:0]  code;
    logic [7:0]  ch;
    logic [7:0]  tr;
    logic [7:0]  tc;
    logic [10:0] idx;
    roll = $urandom_range(0, 99);
    ch   = $urandom_range(0, 255);
    tr   = $urandom_range(0, 255);
    tc   = $urandom_range(0, 255);
    idx  = $urandom_range(0, 2047);
    if (roll < 56) begin
      code = OP_PUT;
      pick = $urandom_range(0, 99);
      if (pick < 60)      ch = $urandom_range(CH_SPACE, CH_LAST_PRINT);
      else if (pick < 68) ch = CH_LF;
      else if (pick < 73) ch = CH_CR;
      else if (pick < 79) ch = CH_TAB;
      else if (pick < 86) ch = CH_BS;
      else if (pick < 93) ch = $urandom_range(8'h80, 8'hFF);
      else                ch = $urandom_range(8'h00, 8'h1F);
    end else if (roll < 68) begin
      code = OP_SET;
      // Mostly in range, with the right edge favored so tabs and text wrap often.
      if ($urandom_range(0, 9) < 7) begin
        tr = $urandom_range(0, TCW_ROWS - 1);
        tc = ($urandom_range(0, 9) < 3) ? $urandom_range(TCW_COLUMNS - 8, TCW_COLUMNS - 1)
                                        : $urandom_range(0, TCW_COLUMNS - 1);
      end
    end else if (roll < 86) begin
      code = OP_READ;
      if ($urandom_range(0, 1)) idx = $urandom_range(0, TCW_ROWS * TCW_COLUMNS - 1);
    end else if (roll < 89) begin
      code = OP_SCROLL_UP;
    end else if (roll < 92) begin
      code = OP_SCROLL_DN;
    end else if (roll < 94) begin
      code = OP_CLEAR;
    end else if (roll < 97) begin
      code = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    end else begin
      // Put with any byte at all.
      code = OP_PUT;
    end
    send_item(code, ch, tr, tc, idx, may_idle);
  endtask

  initial begin
    logic [7:0] attr_value;
    shadow     = new();
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = 8'd0;
    start      = 1'b0;
    op         = OP_PUT;
    char_code  = 8'd0;
    target_row = 8'd0;
    target_col = 8'd0;
    cell_index = 11'd0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // The block runs a clearing pass after reset and reports busy meanwhile.
    settle();

    // Directed part, with the reset attribute.
    read_at(11'd0);                      // reset contents are blank cells
    read_at(11'd1999);                   // last cell of the store
    read_at(11'd2000);                   // first index past the store reads zero
    read_at(11'd2047);                   // all index bits set
    put_byte(8'h41);                     // printable, cursor advances
    put_byte(CH_LAST_PRINT);             // top of the printable range
    put_byte(CH_SPACE);                  // bottom of the printable range
    put_byte(8'h80);                     // high bytes are ignored
    put_byte(8'hFF);
    put_byte(8'h00);                     // so are controls without a meaning
    put_byte(CH_BS);                     // steps back and blanks the cell
    read_at(11'd2);
    put_byte(CH_TAB);                    // rounds up to the next tab stop
    put_byte(CH_CR);
    put_byte(CH_BS);                     // backspace at column zero does nothing
    put_byte(CH_LF);
    send_item(OP_SET, 8'd0, 8'hFF, 8'hFF, 11'd0, 1'b0);  // both coordinates saturate
    put_byte(8'h5A);                     // last cell: wraps and scrolls the screen
    read_at(11'd1919);                   // the character moved up one row
    send_item(OP_SET, 8'd0, 8'd24, 8'd75, 11'd0, 1'b0);
    put_byte(CH_TAB);                    // tab past the last column wraps and scrolls
    put_byte(CH_LF);                     // newline on the bottom row scrolls too
    send_item(OP_SCROLL_UP, 8'd0, 8'd0, 8'd0, 11'd0, 1'b0);
    send_item(OP_SCROLL_DN, 8'd0, 8'd0, 8'd0, 11'd0, 1'b0);
    send_item(OP_SPARE_A, 8'hFF, 8'hFF, 8'hFF, 11'h7FF, 1'b0);
    send_item(OP_SPARE_B, 8'hFF, 8'hFF, 8'hFF, 11'h7FF, 1'b0);
    send_item(OP_CLEAR, 8'd0, 8'd0, 8'd0, 11'd0, 1'b0);
    read_at(11'd0);

    // Random part in phases. Before each phase the sender holds off until every
    // report is back, and only then is the attribute changed: first the two
    // extremes, then random values. The second phase has a long run of items
    // with start never dropped.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 0)      attr_value = 8'h00;
      else if (ph == 1) attr_value = 8'hFF;
      else              attr_value = $urandom_range(0, 255);
      write_attr(attr_value);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        random_item(!(ph == 1 && i >= 30 && i < 120));
    end

    // Drain, then keep watching to catch any stray strobe before closing out.
    settle();
    repeat (8) @(posedge clk);
    shadow.close_out();
    if (shadow.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_cursor.sv
sv/text_console_char_writer_unit.sv
sv/tcw_checker.sv
test/tb_text_console_char_writer_unit.sv
